>>> sv/full_angle_about_normal_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the full angle about normal unit
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FULL_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH
`define FULL_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH

`ifndef SYNTH

// Antecedent in the same cycle implies consequent.
`define FAN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Expression must never be true.
`define FAN_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`else

`define FAN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FAN_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> sv/fan_pkg.sv
// ----------------------------------------------------------------------------
// fan_pkg
// Types, constants and the arctangent table for the full angle unit.
// ----------------------------------------------------------------------------
package fan_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int SQRT_STEPS     = 31;
    // front stages: s0..s12
    localparam int FRONT_STAGES   = 13;
    localparam int PIPE_DEPTH     = FRONT_STAGES + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
    // valid bit that travels with the CORDIC setup registers
    localparam int CORDIC_START   = FRONT_STAGES + SQRT_STEPS;

    localparam int XW = 36;   // CORDIC datapath width
    localparam logic signed [XW-1:0] QUARTER_TURN = XW'(64'sd1073741824);

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } in_t;

    typedef struct packed {
        logic [15:0] full_angle;
        logic        degenerate;
    } out_t;

    typedef struct packed {
        logic degen;
        logic mirror;
        logic dtneg;
    } meta_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [XW-1:0] atan_turn(input int i);
        logic signed [XW-1:0] val;
        case (i)
            0:  val = XW'(64'sd536870912);
            1:  val = XW'(64'sd316933406);
            2:  val = XW'(64'sd167458907);
            3:  val = XW'(64'sd85004756);
            4:  val = XW'(64'sd42667331);
            5:  val = XW'(64'sd21354465);
            6:  val = XW'(64'sd10679838);
            7:  val = XW'(64'sd5340245);
            8:  val = XW'(64'sd2670163);
            9:  val = XW'(64'sd1335087);
            10: val = XW'(64'sd667544);
            11: val = XW'(64'sd333772);
            12: val = XW'(64'sd166886);
            13: val = XW'(64'sd83443);
            14: val = XW'(64'sd41722);
            15: val = XW'(64'sd20861);
            16: val = XW'(64'sd10430);
            17: val = XW'(64'sd5215);
            18: val = XW'(64'sd2608);
            19: val = XW'(64'sd1304);
            20: val = XW'(64'sd652);
            21: val = XW'(64'sd326);
            22: val = XW'(64'sd163);
            23: val = XW'(64'sd81);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> sv/full_angle_about_normal_unit.sv
// ----------------------------------------------------------------------------
// full_angle_about_normal_unit
// Signed angle from a first to a second vector, turning about a normal.
// ----------------------------------------------------------------------------
// The result strobe (done) marks the start transfer reaching the output register.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Depth is set by the 31-stage square root and the 16-stage CORDIC.
// Reset: rst_n clears all valid bits; results in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "full_angle_about_normal_unit_assert.svh"

module full_angle_about_normal_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fan_pkg::in_t   item,
    output logic           done,
    output fan_pkg::out_t  result
);

    // Valid bits, one per register stage
    logic [fan_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic                           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[fan_pkg::PIPE_DEPTH-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // s0: capture the transfer
    // ------------------------------------------------------------------
    fan_pkg::in_t in_reg;

    always_ff @(posedge clk)
    begin
        in_reg <= item;
    end

    // ------------------------------------------------------------------
    // s1: v.n partial products; s2: v.n sums (Q6.28, exact)
    // ------------------------------------------------------------------
    logic signed [15:0] v1_reg [3], v2_reg [3], n_reg [3];
    logic signed [31:0] pvn1_reg [3], pvn2_reg [3];
    logic signed [15:0] v1b_reg [3], v2b_reg [3], nb_reg [3];
    logic signed [33:0] d1_reg, d2_reg;

    always_ff @(posedge clk)
    begin
        v1_reg[0] <= in_reg.first_x;
        v1_reg[1] <= in_reg.first_y;
        v1_reg[2] <= in_reg.first_z;
        v2_reg[0] <= in_reg.second_x;
        v2_reg[1] <= in_reg.second_y;
        v2_reg[2] <= in_reg.second_z;
        n_reg[0]  <= in_reg.normal_x;
        n_reg[1]  <= in_reg.normal_y;
        n_reg[2]  <= in_reg.normal_z;
        pvn1_reg[0] <= 32'(in_reg.first_x)  * 32'(in_reg.normal_x);
        pvn1_reg[1] <= 32'(in_reg.first_y)  * 32'(in_reg.normal_y);
        pvn1_reg[2] <= 32'(in_reg.first_z)  * 32'(in_reg.normal_z);
        pvn2_reg[0] <= 32'(in_reg.second_x) * 32'(in_reg.normal_x);
        pvn2_reg[1] <= 32'(in_reg.second_y) * 32'(in_reg.normal_y);
        pvn2_reg[2] <= 32'(in_reg.second_z) * 32'(in_reg.normal_z);

        v1b_reg <= v1_reg;
        v2b_reg <= v2_reg;
        nb_reg  <= n_reg;
        d1_reg  <= 34'(pvn1_reg[0]) + 34'(pvn1_reg[1]) + 34'(pvn1_reg[2]);
        d2_reg  <= 34'(pvn2_reg[0]) + 34'(pvn2_reg[1]) + 34'(pvn2_reg[2]);
    end

    // ------------------------------------------------------------------
    // s3: n*(v.n); s4: projection, rounded half up to Q.14
    // ------------------------------------------------------------------
    logic signed [49:0] nd1_reg [3], nd2_reg [3];
    logic signed [15:0] v1c_reg [3], v2c_reg [3], nc_reg [3], nd_reg [3];
    logic signed [19:0] p1_reg [3], p2_reg [3];
    logic signed [51:0] t1 [3], t2 [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t1[k] = (52'(v1c_reg[k]) <<< 28) - 52'(nd1_reg[k]) + 52'sd134217728;
            t2[k] = (52'(v2c_reg[k]) <<< 28) - 52'(nd2_reg[k]) + 52'sd134217728;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            nd1_reg[k] <= 50'(nb_reg[k]) * 50'(d1_reg);
            nd2_reg[k] <= 50'(nb_reg[k]) * 50'(d2_reg);
            p1_reg[k]  <= t1[k][47:28];
            p2_reg[k]  <= t2[k][47:28];
        end
        v1c_reg <= v1b_reg;
        v2c_reg <= v2b_reg;
        nc_reg  <= nb_reg;
        nd_reg  <= nc_reg;
    end

    // ------------------------------------------------------------------
    // s5: products for orientation, cross and dot; zero-projection test
    // ------------------------------------------------------------------
    logic signed [35:0] np_reg [6];
    logic signed [39:0] pp_reg [6];
    logic signed [39:0] dp_reg [3];
    logic signed [19:0] p2b_reg [3];
    logic               degen5_reg;

    always_ff @(posedge clk)
    begin
        np_reg[0] <= 36'(nd_reg[1]) * 36'(p1_reg[2]);
        np_reg[1] <= 36'(nd_reg[2]) * 36'(p1_reg[1]);
        np_reg[2] <= 36'(nd_reg[2]) * 36'(p1_reg[0]);
        np_reg[3] <= 36'(nd_reg[0]) * 36'(p1_reg[2]);
        np_reg[4] <= 36'(nd_reg[0]) * 36'(p1_reg[1]);
        np_reg[5] <= 36'(nd_reg[1]) * 36'(p1_reg[0]);
        pp_reg[0] <= 40'(p1_reg[1]) * 40'(p2_reg[2]);
        pp_reg[1] <= 40'(p1_reg[2]) * 40'(p2_reg[1]);
        pp_reg[2] <= 40'(p1_reg[2]) * 40'(p2_reg[0]);
        pp_reg[3] <= 40'(p1_reg[0]) * 40'(p2_reg[2]);
        pp_reg[4] <= 40'(p1_reg[0]) * 40'(p2_reg[1]);
        pp_reg[5] <= 40'(p1_reg[1]) * 40'(p2_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            dp_reg[k] <= 40'(p1_reg[k]) * 40'(p2_reg[k]);
        end
        p2b_reg    <= p2_reg;
        degen5_reg <= ((p1_reg[0] == '0) && (p1_reg[1] == '0) && (p1_reg[2] == '0)) ||
                      ((p2_reg[0] == '0) && (p2_reg[1] == '0) && (p2_reg[2] == '0));
    end

    // ------------------------------------------------------------------
    // s6: n x p1, p1 x p2, p1.p2
    // ------------------------------------------------------------------
    logic signed [36:0] c_reg [3];
    logic signed [40:0] cr_reg [3];
    logic signed [41:0] dt_reg;
    logic signed [19:0] p2c_reg [3];
    logic               degen6_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_reg[k]  <= 37'(np_reg[2*k]) - 37'(np_reg[2*k+1]);
            cr_reg[k] <= 41'(pp_reg[2*k]) - 41'(pp_reg[2*k+1]);
        end
        dt_reg     <= 42'(dp_reg[0]) + 42'(dp_reg[1]) + 42'(dp_reg[2]);
        p2c_reg    <= p2b_reg;
        degen6_reg <= degen5_reg;
    end

    // ------------------------------------------------------------------
    // s7: orientation products, magnitudes; s8: orientation sign, pair max
    // ------------------------------------------------------------------
    logic signed [56:0] rp_reg [3];
    logic [41:0]        ab7_reg [4];
    logic               dtneg7_reg, degen7_reg;
    logic [41:0]        ab8_reg [4];
    logic [41:0]        m01_reg, m23_reg;
    fan_pkg::meta_t     meta8_reg;
    logic signed [58:0] right_sum;

    assign right_sum = 59'(rp_reg[0]) + 59'(rp_reg[1]) + 59'(rp_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            rp_reg[k]  <= 57'(c_reg[k]) * 57'(p2c_reg[k]);
            ab7_reg[k] <= cr_reg[k][40] ? 42'(-42'(cr_reg[k])) : 42'(cr_reg[k]);
        end
        ab7_reg[3] <= dt_reg[41] ? 42'(-dt_reg) : 42'(dt_reg);
        dtneg7_reg <= dt_reg[41];
        degen7_reg <= degen6_reg;

        ab8_reg          <= ab7_reg;
        m01_reg          <= (ab7_reg[1] > ab7_reg[0]) ? ab7_reg[1] : ab7_reg[0];
        m23_reg          <= (ab7_reg[3] > ab7_reg[2]) ? ab7_reg[3] : ab7_reg[2];
        meta8_reg.degen  <= degen7_reg;
        meta8_reg.mirror <= right_sum[58];
        meta8_reg.dtneg  <= dtneg7_reg;
    end

    // ------------------------------------------------------------------
    // s9: common shift so all magnitudes fall below 2^30
    // s10: shifted magnitudes; s11: squares; s12: squared length
    // ------------------------------------------------------------------
    logic [41:0]    m_max;
    logic [3:0]     shift_next;
    logic [3:0]     shift_reg;
    logic [41:0]    ab9_reg [4];
    fan_pkg::meta_t meta9_reg, meta10_reg, meta11_reg;
    logic [29:0]    sh10_reg [4];
    logic [59:0]    sq11_reg [3];
    logic [29:0]    ad11_reg;
    logic [63:0]    sq_v_reg [fan_pkg::SQRT_STEPS+1];
    logic [63:0]    sq_r_reg [fan_pkg::SQRT_STEPS+1];
    logic [29:0]    sq_ad_reg [fan_pkg::SQRT_STEPS+1];
    fan_pkg::meta_t sq_meta_reg [fan_pkg::SQRT_STEPS+1];

    always_comb
    begin
        m_max      = (m23_reg > m01_reg) ? m23_reg : m01_reg;
        shift_next = '0;
        for (int i = 30; i < 42; i++)
        begin
            if (m_max[i])
            begin
                shift_next = 4'(i - 29);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        ab9_reg   <= ab8_reg;
        meta9_reg <= meta8_reg;

        for (int k = 0; k < 4; k++)
        begin
            sh10_reg[k] <= 30'(ab9_reg[k] >> shift_reg);
        end
        meta10_reg <= meta9_reg;

        for (int k = 0; k < 3; k++)
        begin
            sq11_reg[k] <= 60'(sh10_reg[k]) * 60'(sh10_reg[k]);
        end
        ad11_reg   <= sh10_reg[3];
        meta11_reg <= meta10_reg;

        sq_v_reg[0]    <= 64'(sq11_reg[0]) + 64'(sq11_reg[1]) + 64'(sq11_reg[2]);
        sq_r_reg[0]    <= '0;
        sq_ad_reg[0]   <= ad11_reg;
        sq_meta_reg[0] <= meta11_reg;
    end

    // ------------------------------------------------------------------
    // Floor square root: one result bit per stage
    // ------------------------------------------------------------------
    genvar gk;
    generate
        for (gk = 0; gk < fan_pkg::SQRT_STEPS; gk++)
        begin : g_sqrt
            logic [63:0] bit_c;
            logic [63:0] trial;
            assign bit_c = 64'(1) << (2 * (fan_pkg::SQRT_STEPS - 1 - gk));
            assign trial = sq_r_reg[gk] + bit_c;

            always_ff @(posedge clk)
            begin
                if (sq_v_reg[gk] >= trial)
                begin
                    sq_v_reg[gk+1] <= sq_v_reg[gk] - trial;
                    sq_r_reg[gk+1] <= (sq_r_reg[gk] >> 1) + bit_c;
                end
                else
                begin
                    sq_v_reg[gk+1] <= sq_v_reg[gk];
                    sq_r_reg[gk+1] <= sq_r_reg[gk] >> 1;
                end
                sq_ad_reg[gk+1]   <= sq_ad_reg[gk];
                sq_meta_reg[gk+1] <= sq_meta_reg[gk];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // CORDIC setup: a negative cosine starts with a quarter turn
    // ------------------------------------------------------------------
    logic signed [fan_pkg::XW-1:0] cx_reg [fan_pkg::CORDIC_STEPS+1];
    logic signed [fan_pkg::XW-1:0] cy_reg [fan_pkg::CORDIC_STEPS+1];
    logic signed [fan_pkg::XW-1:0] cz_reg [fan_pkg::CORDIC_STEPS+1];
    fan_pkg::meta_t                cm_reg [fan_pkg::CORDIC_STEPS+1];
    logic signed [fan_pkg::XW-1:0] mag_s, ad_s;
    logic                          pre_rot;

    assign mag_s   = fan_pkg::XW'(sq_r_reg[fan_pkg::SQRT_STEPS][30:0]);
    assign ad_s    = fan_pkg::XW'(sq_ad_reg[fan_pkg::SQRT_STEPS]);
    assign pre_rot = sq_meta_reg[fan_pkg::SQRT_STEPS].dtneg && (ad_s != '0);

    always_ff @(posedge clk)
    begin
        if (pre_rot)
        begin
            cx_reg[0] <= mag_s;
            cy_reg[0] <= ad_s;
            cz_reg[0] <= fan_pkg::QUARTER_TURN;
        end
        else
        begin
            cx_reg[0] <= ad_s;
            cy_reg[0] <= mag_s;
            cz_reg[0] <= '0;
        end
        cm_reg[0] <= sq_meta_reg[fan_pkg::SQRT_STEPS];
    end

    generate
        for (gk = 0; gk < fan_pkg::CORDIC_STEPS; gk++)
        begin : g_cordic
            logic signed [fan_pkg::XW-1:0] dx, dy;
            assign dx = cy_reg[gk] >>> gk;
            assign dy = cx_reg[gk] >>> gk;

            always_ff @(posedge clk)
            begin
                if (!cy_reg[gk][fan_pkg::XW-1])
                begin
                    cx_reg[gk+1] <= cx_reg[gk] + dx;
                    cy_reg[gk+1] <= cy_reg[gk] - dy;
                    cz_reg[gk+1] <= cz_reg[gk] + fan_pkg::atan_turn(gk);
                end
                else
                begin
                    cx_reg[gk+1] <= cx_reg[gk] - dx;
                    cy_reg[gk+1] <= cy_reg[gk] + dy;
                    cz_reg[gk+1] <= cz_reg[gk] - fan_pkg::atan_turn(gk);
                end
                cm_reg[gk+1] <= cm_reg[gk];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output: round to 2^-16 turn, zero when degenerate, else mirror on negative orientation
    // ------------------------------------------------------------------
    logic signed [fan_pkg::XW-1:0] z_rnd;
    logic [15:0]                   ang;
    fan_pkg::meta_t                mfin;
    fan_pkg::out_t                 result_reg, result_next;

    assign z_rnd = cz_reg[fan_pkg::CORDIC_STEPS] + fan_pkg::XW'(32768);
    assign ang   = z_rnd[31:16];
    assign mfin  = cm_reg[fan_pkg::CORDIC_STEPS];

    always_comb
    begin
        result_next.degenerate = mfin.degen;
        if (mfin.degen)
        begin
            result_next.full_angle = '0;
        end
        else if (mfin.mirror)
        begin
            result_next.full_angle = 16'(-ang);
        end
        else
        begin
            result_next.full_angle = ang;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = vld_reg[fan_pkg::PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // Checks (data checks only where the stage holds a live item; s8 is vld_reg[8])
    // ------------------------------------------------------------------
    `FAN_ASSERT_IMPLY(a_done_from_start, clk, rst_n, done, $past(accept, fan_pkg::PIPE_DEPTH))
    `FAN_ASSERT_IMPLY(a_degen_zero, clk, rst_n, done && result.degenerate, result.full_angle == '0)
    `FAN_ASSERT_IMPLY(a_degen_no_mirror, clk, rst_n, vld_reg[8] && meta8_reg.degen, !meta8_reg.mirror)
    `FAN_ASSERT_IMPLY(a_cordic_y_start, clk, rst_n, vld_reg[fan_pkg::CORDIC_START], cy_reg[0] >= 0)

endmodule
